// File: rtl/core/bcce_pkg.sv
// Shared types, constants and CRC helper functions for the byte command CRC echo block.
package bcce_pkg;

	localparam int unsigned CRC_DATA_BYTES = 16;
	localparam int unsigned CNT_W = 5;
	localparam int unsigned LEN_BYTES = 4;

	localparam logic [7:0] CMD_CRC = 8'd5;
	localparam logic [7:0] CMD_ECHO = 8'd10;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam int unsigned SUFFIX_LEN = 16;
	localparam int unsigned SFX_IDX_W = $clog2(SUFFIX_LEN);

	localparam int unsigned CRC_BYTES = 4;
	localparam int unsigned EMIT_IDX_W = $clog2(CRC_BYTES);

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_CRC,
		MODE_LEN,
		MODE_ECHO
	} mode_t;

	typedef enum logic {
		OP_CRC,
		OP_ECHO
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] data;
		logic       last;
	} op_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} word_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DATA,
		BK_SUFFIX,
		BK_EMIT
	} bk_state_t;

	function automatic logic [7:0] suffix_byte(input logic [SFX_IDX_W-1:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd0:  b = 8'h54;
			4'd1:  b = 8'h41;
			4'd2:  b = 8'h4D;
			4'd3:  b = 8'h55;
			4'd4:  b = 8'h20;
			4'd5:  b = 8'h52;
			4'd6:  b = 8'h6F;
			4'd7:  b = 8'h62;
			4'd8:  b = 8'h6F;
			4'd9:  b = 8'h4D;
			4'd10: b = 8'h61;
			4'd11: b = 8'h73;
			4'd12: b = 8'h74;
			4'd13: b = 8'h65;
			4'd14: b = 8'h72;
			4'd15: b = 8'h73;
		endcase
		return b;
	endfunction

	function automatic logic [31:0] crc_bit(input logic [31:0] crc, input logic din);
		logic fb;
		fb = crc[0] ^ din;
		return (crc >> 1) ^ (fb ? CRC_POLY : 32'h0000_0000);
	endfunction

endpackage

// File: rtl/core/bcce_front.sv
// Front end: parses commands and lengths and queues data and echo operations.
module bcce_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic [7:0]     data_byte,
	output logic           full,
	input  logic           q_full,
	output logic           q_push,
	output bcce_pkg::op_t  q_word
);

	bcce_pkg::mode_t            mode_q, mode_d;
	logic [bcce_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
	logic [31:0]                rem_q, rem_d, len_new;
	logic                       accept;

	assign full = q_full;
	assign accept = push & ~q_full;
	assign cnt_inc = cnt_q + bcce_pkg::CNT_W'(1);
	assign len_new = {rem_q[23:0], data_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bcce_pkg::MODE_IDLE;
			cnt_q <= '0;
			rem_q <= '0;
		end else begin
			mode_q <= mode_d;
			cnt_q <= cnt_d;
			rem_q <= rem_d;
		end
	end

	always_comb begin
		mode_d = mode_q;
		cnt_d = cnt_q;
		rem_d = rem_q;
		q_push = 1'b0;
		q_word.kind = bcce_pkg::OP_CRC;
		q_word.data = data_byte;
		q_word.last = 1'b0;
		if (accept) begin
			unique case (mode_q)
				bcce_pkg::MODE_IDLE: begin
					if (data_byte == bcce_pkg::CMD_CRC) begin
						mode_d = bcce_pkg::MODE_CRC;
						cnt_d = '0;
					end else if (data_byte == bcce_pkg::CMD_ECHO) begin
						mode_d = bcce_pkg::MODE_LEN;
						cnt_d = '0;
						rem_d = '0;
					end
				end
				bcce_pkg::MODE_CRC: begin
					q_push = 1'b1;
					q_word.last = (cnt_inc == bcce_pkg::CNT_W'(bcce_pkg::CRC_DATA_BYTES));
					cnt_d = cnt_inc;
					if (q_word.last) begin
						mode_d = bcce_pkg::MODE_IDLE;
						cnt_d = '0;
					end
				end
				bcce_pkg::MODE_LEN: begin
					rem_d = len_new;
					cnt_d = cnt_inc;
					if (cnt_inc == bcce_pkg::CNT_W'(bcce_pkg::LEN_BYTES)) begin
						cnt_d = '0;
						mode_d = (len_new == 32'd0) ? bcce_pkg::MODE_IDLE
						                            : bcce_pkg::MODE_ECHO;
					end
				end
				bcce_pkg::MODE_ECHO: begin
					q_push = 1'b1;
					q_word.kind = bcce_pkg::OP_ECHO;
					q_word.last = (rem_q == 32'd1);
					if (rem_q <= 32'd1) begin
						mode_d = bcce_pkg::MODE_IDLE;
						rem_d = '0;
					end else begin
						rem_d = rem_q - 32'd1;
					end
				end
			endcase
		end
	end

endmodule

// File: rtl/core/bcce_opq.sv
// Short operation queue between the front end and the back end.
module bcce_opq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bcce_pkg::op_t  wdata,
	output logic           full,
	input  logic           pop,
	output bcce_pkg::op_t  rdata,
	output logic           empty
);

	bcce_pkg::op_t                 mem_q [bcce_pkg::QUEUE_DEPTH];
	logic [bcce_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [bcce_pkg::QUEUE_CW-1:0] count_q;
	logic                          do_push, do_pop;

	assign full = (count_q == bcce_pkg::QUEUE_CW'(bcce_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop = pop & ~empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + bcce_pkg::QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + bcce_pkg::QUEUE_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + bcce_pkg::QUEUE_CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - bcce_pkg::QUEUE_CW'(1);
			end
		end
	end

endmodule

// File: rtl/core/bcce_back.sv
// Back end: bit-serial CRC engine, suffix pass, reply sequencer and result queue.
module bcce_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_empty,
	input  bcce_pkg::op_t  op_word,
	output logic           op_pop,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     out_byte,
	output logic           last_of_run
);

	bcce_pkg::bk_state_t               state_q, state_d;
	logic [31:0]                       crc_q, crc_next, res_q;
	logic [7:0]                        sh_q;
	logic [2:0]                        bit_q;
	logic [bcce_pkg::SFX_IDX_W-1:0]    sidx_q, sidx_d;
	logic [bcce_pkg::EMIT_IDX_W-1:0]   eidx_q;
	logic                              last_q;
	logic                              step, load_op, load_sfx, finish, emit;

	bcce_pkg::word_t                   oq_mem_q [bcce_pkg::QUEUE_DEPTH];
	logic [bcce_pkg::QUEUE_AW-1:0]     oq_wr_q, oq_rd_q;
	logic [bcce_pkg::QUEUE_CW-1:0]     oq_cnt_q;
	logic                              oq_full, oq_push, oq_pop;
	bcce_pkg::word_t                   oq_wdata, oq_rdata;

	assign crc_next = bcce_pkg::crc_bit(crc_q, sh_q[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcce_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op_pop = 1'b0;
		oq_push = 1'b0;
		oq_wdata.out_byte = op_word.data;
		oq_wdata.last_of_run = op_word.last;
		step = 1'b0;
		load_op = 1'b0;
		load_sfx = 1'b0;
		finish = 1'b0;
		emit = 1'b0;
		sidx_d = sidx_q + bcce_pkg::SFX_IDX_W'(1);
		unique case (state_q)
			bcce_pkg::BK_IDLE: begin
				if (!op_empty) begin
					if (op_word.kind == bcce_pkg::OP_ECHO) begin
						if (!oq_full) begin
							oq_push = 1'b1;
							op_pop = 1'b1;
						end
					end else begin
						op_pop = 1'b1;
						load_op = 1'b1;
						state_d = bcce_pkg::BK_DATA;
					end
				end
			end
			bcce_pkg::BK_DATA: begin
				step = 1'b1;
				sidx_d = '0;
				if (bit_q == 3'd7) begin
					if (last_q) begin
						load_sfx = 1'b1;
						state_d = bcce_pkg::BK_SUFFIX;
					end else begin
						state_d = bcce_pkg::BK_IDLE;
					end
				end
			end
			bcce_pkg::BK_SUFFIX: begin
				step = 1'b1;
				if (bit_q == 3'd7) begin
					if (sidx_q == bcce_pkg::SFX_IDX_W'(bcce_pkg::SUFFIX_LEN - 1)) begin
						finish = 1'b1;
						state_d = bcce_pkg::BK_EMIT;
					end else begin
						load_sfx = 1'b1;
					end
				end
			end
			bcce_pkg::BK_EMIT: begin
				oq_wdata.out_byte = res_q[31:24];
				oq_wdata.last_of_run =
					(eidx_q == bcce_pkg::EMIT_IDX_W'(bcce_pkg::CRC_BYTES - 1));
				if (!oq_full) begin
					oq_push = 1'b1;
					emit = 1'b1;
					if (oq_wdata.last_of_run) begin
						state_d = bcce_pkg::BK_IDLE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= bcce_pkg::CRC_INIT;
			bit_q <= '0;
			sidx_q <= '0;
			eidx_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (load_op) begin
				bit_q <= '0;
				last_q <= op_word.last;
			end
			if (step) begin
				crc_q <= crc_next;
				bit_q <= bit_q + 3'd1;
			end
			if (load_sfx) begin
				sidx_q <= sidx_d;
			end
			if (finish) begin
				crc_q <= bcce_pkg::CRC_INIT;
				eidx_q <= '0;
			end
			if (emit) begin
				eidx_q <= eidx_q + bcce_pkg::EMIT_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_op) begin
			sh_q <= op_word.data;
		end else if (load_sfx) begin
			sh_q <= bcce_pkg::suffix_byte(sidx_d);
		end else if (step) begin
			sh_q <= sh_q >> 1;
		end
		if (finish) begin
			res_q <= ~crc_next;
		end else if (emit) begin
			res_q <= res_q << 8;
		end
	end

	// Result queue toward the output ports.
	assign oq_full = (oq_cnt_q == bcce_pkg::QUEUE_CW'(bcce_pkg::QUEUE_DEPTH));
	assign empty = (oq_cnt_q == '0);
	assign oq_pop = pop & ~empty;
	assign oq_rdata = oq_mem_q[oq_rd_q];
	assign out_byte = oq_rdata.out_byte;
	assign last_of_run = oq_rdata.last_of_run;

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_mem_q[oq_wr_q] <= oq_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q <= '0;
			oq_rd_q <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= oq_wr_q + bcce_pkg::QUEUE_AW'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + bcce_pkg::QUEUE_AW'(1);
			end
			if (oq_push && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + bcce_pkg::QUEUE_CW'(1);
			end else if (oq_pop && !oq_push) begin
				oq_cnt_q <= oq_cnt_q - bcce_pkg::QUEUE_CW'(1);
			end
		end
	end

endmodule

// File: rtl/core/byte_command_crc_echo.sv
// Top level of the byte command engine that answers with a CRC-32 reply or an echo.
//
//  Channel  | Handshake      | Words
//  ---------+----------------+---------------------------
//  input    | push / full    | data_byte
//  result   | empty / pop    | out_byte, last_of_run
//
// Command, length and echo bytes are taken in one cycle each when the operation queue has room.
// Each CRC data byte is loaded in the back end, then its eight bits are fed into the CRC one at a time.
// After the last data byte the 16 suffix bytes pass through the CRC, then the four reply bytes are queued.
// The asynchronous reset returns both ends to the command state with an empty queue.
// A stalled result queue stalls the back end, which in turn fills the queue and raises full.
module byte_command_crc_echo (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] data_byte,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic          q_full, q_push, q_empty, q_pop;
	bcce_pkg::op_t q_wdata, q_rdata;

	bcce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (data_byte),
		.full      (full),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_word    (q_wdata)
	);

	bcce_opq u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	bcce_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_empty    (q_empty),
		.op_word     (q_rdata),
		.op_pop      (q_pop),
		.pop         (pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule
